FILE: hw/rtl/icg_pkg.sv
// ----------------------------------------------------------------------------
// icg_pkg
// Shared types and constants of the inverse congruential generator: widths,
// register map, reset values, controller states and datapath commands.
// ----------------------------------------------------------------------------
package icg_pkg;

    localparam int VALUE_W  = 32;
    localparam int DIV_LONG = 2 * VALUE_W + 1;            // steps for product reduction
    localparam int DIV_W    = 2 * VALUE_W + 1;            // dividend/quotient shift register
    localparam int T_W      = VALUE_W + 2;                // signed Bezout coefficient
    localparam int CNT_W    = $clog2(DIV_LONG + 1);

    localparam int PDATA_W  = (VALUE_W > 32) ? 64 : 32;
    localparam int ADDR_LSB = $clog2(PDATA_W / 8);
    localparam int PADDR_W  = ADDR_LSB + 2;

    localparam logic [VALUE_W-1:0] MULTIPLIER_RST = VALUE_W'(64'd3);
    localparam logic [VALUE_W-1:0] INCREMENT_RST  = VALUE_W'(64'd1);
    localparam logic [VALUE_W-1:0] MODULUS_RST    = VALUE_W'(64'd4294967189);

    typedef enum logic [1:0] {
        REG_MULTIPLIER = 2'd0,
        REG_INCREMENT  = 2'd1,
        REG_MODULUS    = 2'd2,
        REG_NONE       = 2'd3
    } reg_idx_t;

    typedef enum logic {
        KIND_SEED    = 1'b0,
        KIND_ADVANCE = 1'b1
    } kind_t;

    typedef struct packed {
        logic [VALUE_W-1:0] multiplier;
        logic [VALUE_W-1:0] increment;
        logic [VALUE_W-1:0] modulus;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_DIV,
        ST_SEED_SET,
        ST_X_DIV,
        ST_EU_INIT,
        ST_EU_CHECK,
        ST_EU_DIV,
        ST_EU_MUL,
        ST_EU_UPD,
        ST_INV,
        ST_PROD_MUL,
        ST_PROD_LOAD,
        ST_PROD_DIV,
        ST_DONE,
        ST_ZERO_OUT
    } state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_DIV_SEED,
        DP_DIV_CUR,
        DP_DIV_EU,
        DP_DIV_PROD,
        DP_DIV_STEP,
        DP_SET_CUR_REM,
        DP_SET_CUR_ZERO,
        DP_EU_INIT,
        DP_EU_MUL,
        DP_EU_UPD,
        DP_INV,
        DP_PROD_MUL,
        DP_RESULT,
        DP_RESULT_ZERO
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic r1_zero;
        logic p_small;
    } dp_status_t;

endpackage

FILE: hw/rtl/icg_cfg.sv
// ----------------------------------------------------------------------------
// icg_cfg
// APB register bank: multiplier, increment and modulus.
// ----------------------------------------------------------------------------
module icg_cfg (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [icg_pkg::PADDR_W-1:0] paddr,
    input  logic [icg_pkg::PDATA_W-1:0] pwdata,
    output logic [icg_pkg::PDATA_W-1:0] prdata,
    output logic                    pready,
    output icg_pkg::cfg_t           cfg
);
    import icg_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[PADDR_W-1:ADDR_LSB]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_MULTIPLIER: cfg_next.multiplier = VALUE_W'(pwdata);
                REG_INCREMENT:  cfg_next.increment  = VALUE_W'(pwdata);
                REG_MODULUS:    cfg_next.modulus    = VALUE_W'(pwdata);
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_MULTIPLIER: prdata = PDATA_W'(cfg_reg.multiplier);
            REG_INCREMENT:  prdata = PDATA_W'(cfg_reg.increment);
            REG_MODULUS:    prdata = PDATA_W'(cfg_reg.modulus);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.multiplier <= MULTIPLIER_RST;
            cfg_reg.increment  <= INCREMENT_RST;
            cfg_reg.modulus    <= MODULUS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hw/rtl/icg_datapath.sv
// ----------------------------------------------------------------------------
// icg_datapath
// State register, radix-2 restoring divider shared by every reduction and
// by the Euclid quotients, Bezout coefficient update and final product.
// ----------------------------------------------------------------------------
module icg_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  icg_pkg::dp_cmd_t            cmd,
    input  icg_pkg::cfg_t               cfg,
    input  logic [icg_pkg::VALUE_W-1:0] seed_value,
    output icg_pkg::dp_status_t         status,
    output logic [icg_pkg::VALUE_W-1:0] random_value
);
    import icg_pkg::*;

    logic [VALUE_W-1:0]        cur_reg, cur_next;
    logic [VALUE_W-1:0]        out_reg, out_next;
    logic [DIV_W-1:0]          dq_reg, dq_next;     // dividend in, quotient out
    logic [VALUE_W-1:0]        rem_reg, rem_next;
    logic [VALUE_W-1:0]        dsr_reg, dsr_next;
    logic [VALUE_W-1:0]        r0_reg, r0_next;
    logic [VALUE_W-1:0]        r1_reg, r1_next;
    logic signed [T_W-1:0]     t0_reg, t0_next;
    logic signed [T_W-1:0]     t1_reg, t1_next;
    logic signed [T_W-1:0]     tq_reg, tq_next;
    logic [VALUE_W-1:0]        iv_reg, iv_next;
    logic [2*VALUE_W-1:0]      ai_reg, ai_next;

    logic [VALUE_W:0]          rs;
    logic                      ge;
    logic [VALUE_W:0]          rs_sub;
    logic signed [T_W-1:0]     t0_wrap;
    logic [VALUE_W-1:0]        quo;

    assign rs     = {rem_reg, dq_reg[DIV_W-1]};
    assign ge     = rs >= {1'b0, dsr_reg};
    assign rs_sub = rs - {1'b0, dsr_reg};
    assign quo    = dq_reg[VALUE_W-1:0];
    assign t0_wrap = t0_reg + signed'({2'b00, cfg.modulus});

    assign status.r1_zero = (r1_reg == '0);
    assign status.p_small = (cfg.modulus[VALUE_W-1:1] == '0);
    assign random_value   = out_reg;

    always_comb begin
        cur_next = cur_reg;
        out_next = out_reg;
        dq_next  = dq_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        r0_next  = r0_reg;
        r1_next  = r1_reg;
        t0_next  = t0_reg;
        t1_next  = t1_reg;
        tq_next  = tq_reg;
        iv_next  = iv_reg;
        ai_next  = ai_reg;
        unique case (cmd.op)
            DP_NOP: ;
            DP_DIV_SEED: begin
                dq_next  = {seed_value, {(VALUE_W + 1){1'b0}}};
                rem_next = '0;
                dsr_next = cfg.modulus;
            end
            DP_DIV_CUR: begin
                dq_next  = {cur_reg, {(VALUE_W + 1){1'b0}}};
                rem_next = '0;
                dsr_next = cfg.modulus;
            end
            DP_DIV_EU: begin
                dq_next  = {r0_reg, {(VALUE_W + 1){1'b0}}};
                rem_next = '0;
                dsr_next = r1_reg;
            end
            DP_DIV_PROD: begin
                dq_next  = DIV_W'(ai_reg) + DIV_W'(cfg.increment);
                rem_next = '0;
                dsr_next = cfg.modulus;
            end
            DP_DIV_STEP: begin
                rem_next = ge ? rs_sub[VALUE_W-1:0] : rs[VALUE_W-1:0];
                dq_next  = {dq_reg[DIV_W-2:0], ge};
            end
            DP_SET_CUR_REM:  cur_next = rem_reg;
            DP_SET_CUR_ZERO: cur_next = '0;
            DP_EU_INIT: begin
                r0_next = cfg.modulus;
                r1_next = rem_reg;
                t0_next = '0;
                t1_next = T_W'(1);
            end
            DP_EU_MUL: tq_next = T_W'(signed'({2'b00, quo}) * t1_reg);
            DP_EU_UPD: begin
                r0_next = r1_reg;
                r1_next = rem_reg;
                t0_next = t1_reg;
                t1_next = t0_reg - tq_reg;
            end
            DP_INV: begin
                // inverse exists only when the final gcd is one
                if (r0_reg == VALUE_W'(1))
                    iv_next = t0_reg[T_W-1] ? t0_wrap[VALUE_W-1:0] : t0_reg[VALUE_W-1:0];
                else
                    iv_next = '0;
            end
            DP_PROD_MUL: ai_next = (2*VALUE_W)'(cfg.multiplier) * (2*VALUE_W)'(iv_reg);
            DP_RESULT: begin
                cur_next = rem_reg;
                out_next = rem_reg;
            end
            DP_RESULT_ZERO: begin
                cur_next = '0;
                out_next = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg <= '0;
        end else begin
            cur_reg <= cur_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        r0_reg  <= r0_next;
        r1_reg  <= r1_next;
        t0_reg  <= t0_next;
        t1_reg  <= t1_next;
        tq_reg  <= tq_next;
        iv_reg  <= iv_next;
        ai_reg  <= ai_next;
    end

endmodule

FILE: hw/rtl/icg_ctrl.sv
// ----------------------------------------------------------------------------
// icg_ctrl
// Sequencer: request intake, divider step counting, Euclid loop and the
// result register handshake.
// ----------------------------------------------------------------------------
module icg_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_kind,
    output logic                m_valid,
    input  logic                m_ready,
    input  icg_pkg::dp_status_t status,
    output icg_pkg::dp_cmd_t    cmd
);
    import icg_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             accept;
    logic             last_step;
    logic             out_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid & s_ready;
    assign last_step = (cnt_reg == CNT_W'(1));
    assign out_free  = ~m_valid_reg | m_ready;
    assign m_valid   = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (kind_t'(s_kind) == KIND_SEED)
                        state_next = status.p_small ? ST_IDLE : ST_SEED_DIV;
                    else
                        state_next = status.p_small ? ST_ZERO_OUT : ST_X_DIV;
                end
            end
            ST_SEED_DIV:  if (last_step) state_next = ST_SEED_SET;
            ST_SEED_SET:  state_next = ST_IDLE;
            ST_X_DIV:     if (last_step) state_next = ST_EU_INIT;
            ST_EU_INIT:   state_next = ST_EU_CHECK;
            ST_EU_CHECK:  state_next = status.r1_zero ? ST_INV : ST_EU_DIV;
            ST_EU_DIV:    if (last_step) state_next = ST_EU_MUL;
            ST_EU_MUL:    state_next = ST_EU_UPD;
            ST_EU_UPD:    state_next = ST_EU_CHECK;
            ST_INV:       state_next = ST_PROD_MUL;
            ST_PROD_MUL:  state_next = ST_PROD_LOAD;
            ST_PROD_LOAD: state_next = ST_PROD_DIV;
            ST_PROD_DIV:  if (last_step) state_next = ST_DONE;
            ST_DONE:      if (out_free) state_next = ST_IDLE;
            ST_ZERO_OUT:  if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.op = DP_NOP;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (kind_t'(s_kind) == KIND_SEED)
                        cmd.op = status.p_small ? DP_SET_CUR_ZERO : DP_DIV_SEED;
                    else if (!status.p_small)
                        cmd.op = DP_DIV_CUR;
                end
            end
            ST_SEED_DIV, ST_X_DIV, ST_EU_DIV, ST_PROD_DIV: cmd.op = DP_DIV_STEP;
            ST_SEED_SET:  cmd.op = DP_SET_CUR_REM;
            ST_EU_INIT:   cmd.op = DP_EU_INIT;
            ST_EU_CHECK:  cmd.op = status.r1_zero ? DP_NOP : DP_DIV_EU;
            ST_EU_MUL:    cmd.op = DP_EU_MUL;
            ST_EU_UPD:    cmd.op = DP_EU_UPD;
            ST_INV:       cmd.op = DP_INV;
            ST_PROD_MUL:  cmd.op = DP_PROD_MUL;
            ST_PROD_LOAD: cmd.op = DP_DIV_PROD;
            ST_DONE:      cmd.op = out_free ? DP_RESULT : DP_NOP;
            ST_ZERO_OUT:  cmd.op = out_free ? DP_RESULT_ZERO : DP_NOP;
            default:      cmd.op = DP_NOP;
        endcase
    end

    // step counter: loaded on entry to a divide phase, counts down inside it
    always_comb begin
        cnt_next = cnt_reg;
        if (state_next != state_reg) begin
            if (state_next == ST_SEED_DIV || state_next == ST_X_DIV ||
                state_next == ST_EU_DIV)
                cnt_next = CNT_W'(VALUE_W);
            else if (state_next == ST_PROD_DIV)
                cnt_next = CNT_W'(DIV_LONG);
        end else if (state_reg == ST_SEED_DIV || state_reg == ST_X_DIV ||
                     state_reg == ST_EU_DIV || state_reg == ST_PROD_DIV) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg & ~m_ready;
        if ((state_reg == ST_DONE || state_reg == ST_ZERO_OUT) && out_free)
            m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: hw/rtl/inverse_congruential_generator.sv
// ----------------------------------------------------------------------------
// inverse_congruential_generator
// Inverse congruential generator over a prime modulus: x <- (a*inv(x)+c) mod p.
//
// Input channel (s_valid/s_ready): s_kind 0 loads s_seed_value mod p into the
// state and gives no result; s_kind 1 advances once and gives one result on
// the m_ channel (m_valid/m_ready, m_random_value).
// Configuration: APB writes to multiplier (0x0), increment (0x4) and modulus
// (0x8) are for the user to make only while the block is idle; the block does
// not enforce it. Reads return the registers. All divisions share one radix-2
// restoring divider (one bit a cycle): the seed reduction, the reduction of
// the state, the Euclid quotients of the inverse (below about 47 Euclid steps
// for 32-bit values) and the final product reduction. A modulus below two
// short-cuts both seed and advance to a zero state, and an advance then gives
// a zero result. Reset clears the state to zero and loads multiplier 3,
// increment 1 and modulus 4294967189. The result sits in an output register;
// the next request is taken while it waits, and a finished advance holds in
// its last state until the receiver takes the previous result.
// ----------------------------------------------------------------------------
module inverse_congruential_generator (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_kind,
    input  logic [icg_pkg::VALUE_W-1:0] s_seed_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [icg_pkg::VALUE_W-1:0] m_random_value,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [icg_pkg::PADDR_W-1:0] paddr,
    input  logic [icg_pkg::PDATA_W-1:0] pwdata,
    output logic [icg_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import icg_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    icg_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    icg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    icg_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .cfg          (cfg),
        .seed_value   (s_seed_value),
        .status       (status),
        .random_value (m_random_value)
    );

endmodule

FILE: tb/inverse_congruential_generator_tb.sv
// ----------------------------------------------------------------------------
// inverse_congruential_generator_tb
// Self-checking bench for the inverse congruential generator. Seed and advance
// requests go in on the s_ channel while the APB port steps the multiplier,
// increment and modulus through extreme, prime, composite and degenerate
// settings. A scoreboard mirrors the generator state, predicts each advance
// result and checks the m_ channel in order. Both channels see random stalls.
// ----------------------------------------------------------------------------
module inverse_congruential_generator_tb;

    import icg_pkg::*;

    localparam int PERIOD_HALF   = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 100;     // covers a seed still in flight
    localparam int STALL_LIMIT   = 20000;   // well above the longest advance
    localparam int RAND_PHASES   = 12;
    localparam int PHASE_ITEMS   = 100;

    class icg_scoreboard;
        logic [VALUE_W-1:0] multiplier;
        logic [VALUE_W-1:0] increment;
        logic [VALUE_W-1:0] modulus;
        logic [VALUE_W-1:0] current_value;
        logic [VALUE_W-1:0] expected_values[$];
        int errors     = 0;
        int seeds      = 0;
        int advances   = 0;
        int results    = 0;
        int reg_writes = 0;

        function new();
            multiplier    = MULTIPLIER_RST;
            increment     = INCREMENT_RST;
            modulus       = MODULUS_RST;
            current_value = '0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [VALUE_W-1:0] value);
            reg_writes++;
            case (idx)
                REG_MULTIPLIER: multiplier = value;
                REG_INCREMENT:  increment  = value;
                REG_MODULUS:    modulus    = value;
                default: ;
            endcase
        endfunction

        // extended Euclid; 0 when x is 0 or shares a factor with p
        function logic [VALUE_W-1:0] mod_inverse(logic [VALUE_W-1:0] x, logic [VALUE_W-1:0] p);
            longint r0, r1, t0, t1, q, tmp;
            r0 = longint'(p);
            r1 = longint'(x);
            t0 = 0;
            t1 = 1;
            while (r1 != 0) begin
                q   = r0 / r1;
                tmp = r0 - q * r1;
                r0  = r1;
                r1  = tmp;
                tmp = t0 - q * t1;
                t0  = t1;
                t1  = tmp;
            end
            if (r0 != 1)
                return '0;
            if (t0 < 0)
                t0 += longint'(p);
            return VALUE_W'(t0);
        endfunction

        function void note_request(kind_t kind, logic [VALUE_W-1:0] seed);
            logic [VALUE_W-1:0] x;
            logic [VALUE_W-1:0] inv;
            bit [63:0]          prod;
            bit [63:0]          sum;
            if (kind == KIND_SEED) begin
                seeds++;
                current_value = (modulus < 2) ? '0 : seed % modulus;
                return;
            end
            advances++;
            if (modulus < 2) begin
                current_value = '0;
            end else begin
                x    = current_value % modulus;
                inv  = mod_inverse(x, modulus);
                prod = (64'(multiplier % modulus) * 64'(inv)) % 64'(modulus);
                sum  = (prod + 64'(increment % modulus)) % 64'(modulus);
                current_value = VALUE_W'(sum);
            end
            expected_values.push_back(current_value);
        endfunction

        function void check_result(logic [VALUE_W-1:0] value);
            logic [VALUE_W-1:0] want;
            results++;
            if (expected_values.size() == 0) begin
                $error("random_value: unexpected result %0d", value);
                errors++;
                return;
            end
            want = expected_values.pop_front();
            if (value !== want) begin
                $error("random_value mismatch: expected %0d, actual %0d", want, value);
                errors++;
            end
        endfunction

        function void check_drained();
            if (expected_values.size() != 0) begin
                $error("random_value: %0d results never arrived, next expected %0d",
                       expected_values.size(), expected_values[0]);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_kind;
    logic [VALUE_W-1:0]   s_seed_value;
    logic                 m_valid;
    logic                 m_ready;
    logic [VALUE_W-1:0]   m_random_value;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    icg_scoreboard sb;
    int src_idle_pct  = 22;
    int sink_idle_pct = 47;
    int quiet_cycles  = 0;

    inverse_congruential_generator dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_seed_value   (s_seed_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_random_value (m_random_value),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #PERIOD_HALF aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // monitors and stall watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_request(kind_t'(s_kind), s_seed_value);
            if (m_valid && m_ready)
                sb.check_result(m_random_value);
            if (psel && penable && pwrite && pready)
                sb.write_reg(reg_idx_t'(paddr[ADDR_LSB +: 2]), pwdata[VALUE_W-1:0]);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("stalled for %0d cycles with %0d results outstanding",
                         quiet_cycles, sb.expected_values.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic send_request(input kind_t kind, input logic [VALUE_W-1:0] seed);
        @(negedge aclk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_seed_value <= seed;
        do @(posedge aclk); while (!s_ready);
    endtask

    // drop valid, collect every outstanding result, let a trailing seed finish
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.expected_values.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [VALUE_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, {ADDR_LSB{1'b0}}});
        pwdata  <= PDATA_W'(value);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input logic [VALUE_W-1:0] mult, input logic [VALUE_W-1:0] incr,
                             input logic [VALUE_W-1:0] modulus);
        wait_idle();
        apb_write(REG_MULTIPLIER, mult);
        apb_write(REG_INCREMENT, incr);
        apb_write(REG_MODULUS, modulus);
    endtask

    function automatic logic [VALUE_W-1:0] pick_coeff();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return VALUE_W'($urandom_range(0, 15));
            default: return VALUE_W'($urandom());
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] pick_modulus();
        case ($urandom_range(0, 19))
            0, 1:    return MODULUS_RST;
            2, 3:    return 32'd2147483647;
            4, 5:    return 32'd4294967291;
            6, 7:    return 32'd65521;
            8, 9:    return 32'd251;
            10:      return 32'd3;
            11, 12:  return VALUE_W'($urandom_range(2, 1000));   // mostly composite
            13, 14:  return VALUE_W'($urandom());
            15:      return VALUE_W'($urandom_range(0, 2));
            default: return 32'd101;
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] pick_seed(input logic [VALUE_W-1:0] modulus);
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return modulus;
            3:       return modulus - 1;
            4:       return modulus + 1;
            5:       return VALUE_W'($urandom_range(0, 3));
            default: return VALUE_W'($urandom());
        endcase
    endfunction

    initial begin
        logic [VALUE_W-1:0] modulus;
        sb           = new();
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_kind       = KIND_SEED;
        s_seed_value = '0;
        m_ready      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset configuration; the first advance starts from the zero state
        send_request(KIND_ADVANCE, '1);
        send_request(KIND_ADVANCE, '0);
        send_request(KIND_ADVANCE, 32'h5a5a_a5a5);
        send_request(KIND_SEED, '0);
        send_request(KIND_ADVANCE, 32'h1234_5678);
        send_request(KIND_SEED, '1);
        send_request(KIND_ADVANCE, '0);
        send_request(KIND_SEED, MODULUS_RST);
        send_request(KIND_ADVANCE, '0);
        send_request(KIND_SEED, MODULUS_RST - 1);
        send_request(KIND_ADVANCE, '0);
        send_request(KIND_SEED, 32'd1);
        send_request(KIND_ADVANCE, '0);

        // coefficients above the modulus
        configure('1, '1, MODULUS_RST);
        send_request(KIND_ADVANCE, '0);
        send_request(KIND_SEED, 32'hffff_0000);

        // shrink the modulus under a seeded state
        wait_idle();
        apb_write(REG_MODULUS, 32'd1000003);
        send_request(KIND_ADVANCE, '0);
        send_request(KIND_ADVANCE, '0);

        // composite modulus: a state sharing a factor has no inverse
        configure(32'd7, 32'd11, '1);
        send_request(KIND_SEED, 32'd3);
        send_request(KIND_ADVANCE, '0);
        send_request(KIND_SEED, 32'd2);
        send_request(KIND_ADVANCE, '0);

        // modulus below two, then the smallest prime, then zero coefficients
        configure(32'd5, 32'd9, 32'd1);
        send_request(KIND_SEED, 32'd5);
        send_request(KIND_ADVANCE, '0);
        configure(32'd5, 32'd9, 32'd0);
        send_request(KIND_ADVANCE, '0);
        configure(32'd1, 32'd1, 32'd2);
        send_request(KIND_ADVANCE, '0);
        send_request(KIND_ADVANCE, '0);
        configure('0, '0, 32'd7);
        send_request(KIND_SEED, 32'd6);
        send_request(KIND_ADVANCE, '0);

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            modulus = pick_modulus();
            configure(pick_coeff(), pick_coeff(), modulus);
            if (phase < RAND_PHASES / 3) begin
                src_idle_pct  = 22;
                sink_idle_pct = 47;
            end else if (phase < 2 * RAND_PHASES / 3) begin
                src_idle_pct  = 47;
                sink_idle_pct = 22;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            // seed first, then advances mixed with occasional reseeds
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == 0 || $urandom_range(0, 99) < 18)
                    send_request(KIND_SEED, pick_seed(modulus));
                else
                    send_request(KIND_ADVANCE, VALUE_W'($urandom()));
            end
        end

        wait_idle();
        sb.check_drained();
        $display("ran %0d seed and %0d advance requests, %0d results checked",
                 sb.seeds, sb.advances, sb.results);
        $display("across %0d register writes with prime, composite and degenerate moduli",
                 sb.reg_writes);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
